### rtl/sts_pkg.sv
// Shared types and constants for the scope trigger search block.
// Used by sts_ctrl, sts_datapath and scope_trigger_search; no dependencies.
package sts_pkg;

  // Default geometry of the sample ring
  localparam int RING_DEPTH_DEF   = 2048;
  localparam int SAMPLE_WIDTH_DEF = 12;

  // Fixed field widths
  localparam int SMP_FIELD_W = 12;
  localparam int IDX_W       = 11;
  localparam int REG_W       = 12;
  localparam int CFG_IDX_W   = 1;

  // Search geometry
  localparam int SCAN_OFFSET = 64;
  localparam int SLOPE_SPAN  = 3;

  // Register reset values
  localparam logic [REG_W-1:0] RESET_LEVEL     = 12'd2048;
  localparam logic [REG_W-1:0] RESET_TOLERANCE = 12'd25;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TOLERANCE = 1'd1;

  // Operation codes
  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [SMP_FIELD_W-1:0] sample;
    logic                   rising;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] trigger_index;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic store;      // write input sample into ring
    logic start;      // set up a search
    logic rd;         // issue one ring read
    logic latch_res;  // capture search result
    logic res_hit;    // captured result is a hit
    logic load_out;   // move result into output register
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic issue_done;
    logic eval_valid;
    logic hit;
    logic last_eval;
    logic out_busy;
  } ctl_sts_t;

endpackage

### rtl/scope_trigger_search.sv
// Scope trigger search: level and slope trigger finder over a sample ring.
// Input channel (in_valid/in_ready/in_data) carries store or search transactions.
// A store writes the sample at the next ring position; it gives no result.
// A search scans from 64 positions past the newest sample
// up to half the ring, one position per cycle through the single ring read
// port, and returns one transaction on the output channel (found, index).
// A hit ends the scan early; one item is in work at a time.
// The output register holds a result while the receiver stalls; stores and a
// new search are accepted meanwhile, and a finished search waits in the
// datapath until the output register frees.
// Reset empties the ring logically through a fill count (no clearing pass):
// unwritten positions read as zero. Registers trigger_level and
// level_tolerance reset to 2048 and 25 and are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while idle, which the
// block does not enforce. Depends on sts_pkg, sts_ctrl, sts_datapath, sts_ram.
module scope_trigger_search #(
  parameter int RING_DEPTH   = sts_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = sts_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sts_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sts_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [sts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sts_pkg::REG_W-1:0]     cfg_data
);

  sts_pkg::ctl_cmd_t cmd;
  sts_pkg::ctl_sts_t sts;

  sts_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_data.op),
    .sts      (sts),
    .cmd      (cmd)
  );

  sts_datapath #(
    .RING_DEPTH   (RING_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A miss always reports index zero
  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.trigger_index == '0)
    else $error("miss result with nonzero index");

  // A search transaction makes the block busy on the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.op == sts_pkg::OP_SEARCH) |=> !in_ready)
    else $error("search accepted but block still ready");

  // A store never produces a result
  a_store_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.op == sts_pkg::OP_STORE) && !out_valid
    |=> !out_valid)
    else $error("store produced a result");

endmodule

### rtl/sts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sts_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/sts_ctrl.sv
// Controller state machine for the scope trigger search block.
// Depends on sts_pkg; drives sts_datapath through ctl_cmd_t.
module sts_ctrl #(
  parameter int RING_DEPTH = sts_pkg::RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  sts_pkg::ctl_sts_t sts,
  output sts_pkg::ctl_cmd_t cmd
);

  // No positions to scan on a short ring
  localparam bit SCAN_EN = (RING_DEPTH / 2) > sts_pkg::SCAN_OFFSET;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POST = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_op == sts_pkg::OP_STORE) begin
            cmd.store = 1'b1;
          end else if (SCAN_EN) begin
            cmd.start  = 1'b1;
            state_next = S_SCAN;
          end else begin
            cmd.latch_res = 1'b1;
            state_next    = S_POST;
          end
        end
      end
      S_SCAN: begin
        cmd.rd = !sts.issue_done;
        if (sts.eval_valid && (sts.hit || sts.last_eval)) begin
          cmd.latch_res = 1'b1;
          cmd.res_hit   = sts.hit;
          state_next    = S_POST;
        end
      end
      S_POST: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/sts_datapath.sv
// Datapath: sample ring, fill count, sliding tap window, level and slope test,
// result and output registers. Depends on sts_pkg and sts_ram.
module sts_datapath #(
  parameter int RING_DEPTH   = sts_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = sts_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sts_pkg::ctl_cmd_t                   cmd,
  output sts_pkg::ctl_sts_t                   sts,
  input  sts_pkg::in_item_t                   in_data,
  input  logic                                cfg_we,
  input  logic [sts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sts_pkg::REG_W-1:0]           cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sts_pkg::out_item_t                  out_data
);

  localparam int AW     = $clog2(RING_DEPTH);
  localparam int FW     = $clog2(RING_DEPTH + 1);
  localparam int SPAN   = sts_pkg::SLOPE_SPAN;
  localparam int TAPS   = 2 * SPAN + 1;
  localparam int TCW    = $clog2(TAPS + 1);
  localparam int NSCAN  = ((RING_DEPTH / 2) > sts_pkg::SCAN_OFFSET) ?
                          (RING_DEPTH / 2) - sts_pkg::SCAN_OFFSET : 1;
  localparam int NREAD  = NSCAN + 2 * SPAN;
  localparam int ICW    = $clog2(NREAD + 1);
  localparam int ECW    = $clog2(NSCAN + 1);
  localparam int CW     = ((SAMPLE_WIDTH > sts_pkg::REG_W) ? SAMPLE_WIDTH :
                          sts_pkg::REG_W) + 2;
  localparam logic [AW-1:0] LAST_POS = AW'(RING_DEPTH - 1);

  // Configuration registers
  logic [sts_pkg::REG_W-1:0] trigger_level;
  logic [sts_pkg::REG_W-1:0] level_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level   <= sts_pkg::RESET_LEVEL;
      level_tolerance <= sts_pkg::RESET_TOLERANCE;
    end else if (cfg_we) begin
      case (cfg_index)
        sts_pkg::REG_TRIGGER_LEVEL:   trigger_level   <= cfg_data;
        sts_pkg::REG_LEVEL_TOLERANCE: level_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Newest pointer and fill count; positions at or above fill read as zero
  logic [AW-1:0] newest;
  logic [AW-1:0] store_pos;
  logic [FW-1:0] fill;

  assign store_pos = (newest == LAST_POS) ? '0 : newest + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      newest <= LAST_POS;
      fill   <= '0;
    end else if (cmd.store) begin
      newest <= store_pos;
      if (fill != FW'(RING_DEPTH)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Scan start points, wrapped with one compare and subtract
  logic [AW:0] center_sum;
  logic [AW:0] addr_sum;
  logic [AW-1:0] center_start;
  logic [AW-1:0] addr_start;

  assign center_sum   = {1'b0, newest} + (AW + 1)'(sts_pkg::SCAN_OFFSET);
  assign addr_sum     = {1'b0, newest} + (AW + 1)'(sts_pkg::SCAN_OFFSET - SPAN);
  assign center_start = (center_sum >= (AW + 1)'(RING_DEPTH)) ?
                        AW'(center_sum - (AW + 1)'(RING_DEPTH)) : center_sum[AW-1:0];
  assign addr_start   = (addr_sum >= (AW + 1)'(RING_DEPTH)) ?
                        AW'(addr_sum - (AW + 1)'(RING_DEPTH)) : addr_sum[AW-1:0];

  // Ring memory
  logic [AW-1:0]           rd_addr;
  logic [SAMPLE_WIDTH-1:0] ram_q;

  sts_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (store_pos),
    .wdata (SAMPLE_WIDTH'(in_data.sample)),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Read sequencing and tap window
  logic [ICW-1:0]          issue_cnt;
  logic [ECW-1:0]          eval_cnt;
  logic [AW-1:0]           center;
  logic                    rd_pending;
  logic                    rd_unwritten;
  logic                    fresh;
  logic [TCW-1:0]          tap_cnt;
  logic [SAMPLE_WIDTH-1:0] taps [TAPS];
  logic                    rising_q;
  logic signed [CW-1:0]    win_lo;
  logic signed [CW-1:0]    win_hi;
  logic                    eval_valid;

  assign eval_valid = fresh && (tap_cnt == TCW'(TAPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      fresh      <= 1'b0;
      tap_cnt    <= '0;
      issue_cnt  <= '0;
      eval_cnt   <= '0;
    end else if (cmd.start) begin
      rd_pending <= 1'b0;
      fresh      <= 1'b0;
      tap_cnt    <= '0;
      issue_cnt  <= '0;
      eval_cnt   <= '0;
    end else begin
      rd_pending <= cmd.rd;
      fresh      <= rd_pending;
      if (rd_pending && (tap_cnt != TCW'(TAPS))) begin
        tap_cnt <= tap_cnt + 1'b1;
      end
      if (cmd.rd) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (eval_valid) begin
        eval_cnt <= eval_cnt + 1'b1;
      end
    end
  end

  // Search payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_addr  <= addr_start;
      center   <= center_start;
      rising_q <= in_data.rising;
      win_lo   <= $signed(CW'(trigger_level)) - $signed(CW'(level_tolerance));
      win_hi   <= $signed(CW'(trigger_level)) + $signed(CW'(level_tolerance));
    end else begin
      if (cmd.rd) begin
        rd_addr      <= (rd_addr == LAST_POS) ? '0 : rd_addr + 1'b1;
        rd_unwritten <= ({1'b0, rd_addr} >= fill);
      end
      if (eval_valid) begin
        center <= (center == LAST_POS) ? '0 : center + 1'b1;
      end
    end
    // Shift window: tap 0 is the newest read (after), last tap the oldest (before)
    if (rd_pending) begin
      taps[0] <= rd_unwritten ? '0 : ram_q;
      for (int k = 1; k < TAPS; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  // Level window and slope test on the center tap
  logic signed [CW-1:0] mid_val;
  logic                 in_win;
  logic                 up;

  assign mid_val = $signed(CW'(taps[SPAN]));
  assign in_win  = (mid_val >= win_lo) && (mid_val <= win_hi);
  assign up      = taps[0] > taps[TAPS-1];

  assign sts.issue_done = (issue_cnt == ICW'(NREAD));
  assign sts.eval_valid = eval_valid;
  assign sts.hit        = in_win && (up == rising_q);
  assign sts.last_eval  = (eval_cnt == ECW'(NSCAN - 1));
  assign sts.out_busy   = out_valid && !out_ready;

  // Result and output registers
  logic                      res_found;
  logic [sts_pkg::IDX_W-1:0] res_idx;

  always_ff @(posedge clk) begin
    if (cmd.latch_res) begin
      res_found <= cmd.res_hit;
      res_idx   <= cmd.res_hit ? sts_pkg::IDX_W'(center) : '0;
    end
    if (cmd.load_out) begin
      out_data.found         <= res_found;
      out_data.trigger_index <= res_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
